/* rtl/rnta_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rnta_pkg: shared types and constants
// Types, character codes and helpers for the radix number formatter.
// ---------------------------------------------------------------------------
package rnta_pkg;

  // Digit stack: octal of a 32-bit word needs eleven digits.
  localparam int unsigned STACK_DEPTH = 11;
  localparam int unsigned DIG_W       = 4;
  localparam int unsigned CNT_W       = 4;

  // Character codes.
  localparam logic [7:0] ASCII_ZERO      = 8'd48;
  localparam logic [7:0] ASCII_ALPHA_OFS = 8'd55;
  localparam logic [7:0] ASCII_MINUS     = 8'd45;
  localparam logic [7:0] ASCII_X         = 8'd120;

  // Decimal digit extraction by reciprocal multiply: q = (m * RECIP10) >> 35.
  localparam logic [DIG_W-1:0] DEC_BASE      = 4'd10;
  localparam logic [31:0]      RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP10_SHIFT = 35;

  // Binary mode always prints this many digits.
  localparam logic [CNT_W-1:0] BIN_DIGITS = 4'd8;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_HEX = 2'd1,
    MODE_OCT = 2'd2,
    MODE_BIN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_PFX  = 2'd2,
    ST_DIG  = 2'd3
  } state_t;

  // One classified number as it waits between front and back.
  typedef struct packed {
    logic [31:0] mag;
    mode_t       mode;
    logic        neg;
  } job_t;

  // Digit value to its uppercase ASCII character.
  function automatic logic [7:0] digit_to_ascii(input logic [DIG_W-1:0] d);
    logic [7:0] code;
    if (d < DEC_BASE) begin
      code = ASCII_ZERO + {4'b0000, d};
    end else begin
      code = ASCII_ALPHA_OFS + {4'b0000, d};
    end
    return code;
  endfunction

endpackage
`default_nettype wire

/* rtl/rnta_stream_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rnta_stream_if: channel interfaces
// Valid/ready channels for input numbers and output characters.
// ---------------------------------------------------------------------------
interface rnta_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

interface rnta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

/* rtl/rnta_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rnta_front: input classification
// Accepts numbers and turns them into a magnitude, a sign and a radix mode.
// ---------------------------------------------------------------------------
module rnta_front (
  rnta_in_if.sink        in_s,
  output logic           push_valid,
  input  logic           push_ready,
  output rnta_pkg::job_t push_data
);
  import rnta_pkg::*;

  mode_t       mode_c;
  logic [31:0] raw_c;

  assign mode_c     = mode_t'(in_s.mode);
  assign raw_c      = 32'(unsigned'(in_s.value));
  assign push_valid = in_s.valid;
  assign in_s.ready = push_ready;

  // Decimal negatives print their magnitude; the most negative value wraps to
  // 2147483648, which is correct as an unsigned word. Binary keeps the low byte.
  always_comb begin
    push_data.mode = mode_c;
    push_data.neg  = 1'b0;
    push_data.mag  = raw_c;
    case (mode_c)
      MODE_DEC: begin
        push_data.neg = raw_c[31];
        push_data.mag = raw_c[31] ? (32'd0 - raw_c) : raw_c;
      end
      MODE_BIN: begin
        push_data.mag = {24'd0, raw_c[7:0]};
      end
      default: begin
        push_data.mag = raw_c;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rnta_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rnta_queue: two-entry job queue
// Decouples classification from the conversion engine.
// ---------------------------------------------------------------------------
module rnta_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rnta_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rnta_pkg::job_t pop_data
);
  import rnta_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue lost a push");

endmodule
`default_nettype wire

/* rtl/rnta_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rnta_back: conversion engine
// Extracts digits least significant first onto a stack, then emits the
// prefix and pops the digits out most significant first.
// ---------------------------------------------------------------------------
module rnta_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  rnta_pkg::job_t job_data,
  rnta_out_if.source     out_m
);
  import rnta_pkg::*;

  state_t           state_r, state_nxt;
  logic [31:0]      mag_r, mag_nxt;
  mode_t            mode_r, mode_nxt;
  logic             neg_r, neg_nxt;
  logic [DIG_W-1:0] stack_r [STACK_DEPTH];
  logic [DIG_W-1:0] stack_nxt [STACK_DEPTH];
  logic [CNT_W-1:0] ndig_r, ndig_nxt;
  logic             pfx_idx_r, pfx_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [63:0]      prod;
  logic [31:0]      quot;
  logic [31:0]      rem;
  logic [DIG_W-1:0] digit;
  logic [31:0]      mag_shift;
  logic             conv_done;
  logic [1:0]       pfx_len;
  logic [7:0]       pfx_char;
  logic             can_emit;

  assign out_m.valid     = out_valid_r;
  assign out_m.char_code = out_char_r;
  assign out_m.last      = out_last_r;
  assign can_emit        = !out_valid_r || out_m.ready;
  assign job_ready       = (state_r == ST_IDLE);

  // Divide by ten through the reciprocal; the remainder needs only shifts and subtractions.
  assign prod = {32'd0, mag_r} * {32'd0, RECIP10};
  assign quot = 32'(prod >> RECIP10_SHIFT);
  assign rem  = mag_r - {quot[28:0], 3'b000} - {quot[30:0], 1'b0};

  // One digit per cycle in the selected radix.
  always_comb begin
    case (mode_r)
      MODE_DEC: begin
        digit     = rem[DIG_W-1:0];
        mag_shift = quot;
      end
      MODE_HEX: begin
        digit     = mag_r[3:0];
        mag_shift = {4'd0, mag_r[31:4]};
      end
      MODE_OCT: begin
        digit     = {1'b0, mag_r[2:0]};
        mag_shift = {3'd0, mag_r[31:3]};
      end
      default: begin
        digit     = {3'd0, mag_r[0]};
        mag_shift = {1'b0, mag_r[31:1]};
      end
    endcase
  end

  // Binary runs a fixed count; the others stop when the quotient reaches zero.
  assign conv_done = (mode_r == MODE_BIN) ? (ndig_r == BIN_DIGITS - 4'd1)
                                          : (mag_shift == 32'd0);

  // Prefix length and the character at the current prefix position.
  always_comb begin
    case (mode_r)
      MODE_DEC: begin
        pfx_len  = neg_r ? 2'd1 : 2'd0;
        pfx_char = ASCII_MINUS;
      end
      MODE_HEX: begin
        pfx_len  = 2'd2;
        pfx_char = pfx_idx_r ? ASCII_X : ASCII_ZERO;
      end
      MODE_OCT: begin
        pfx_len  = 2'd1;
        pfx_char = ASCII_ZERO;
      end
      default: begin
        pfx_len  = 2'd0;
        pfx_char = ASCII_ZERO;
      end
    endcase
  end

  // Next state, stack and output register.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    mode_nxt      = mode_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    pfx_idx_nxt   = pfx_idx_r;
    out_valid_nxt = out_m.ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_nxt[i] = stack_r[i];
    end

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          mag_nxt   = job_data.mag;
          mode_nxt  = job_data.mode;
          neg_nxt   = job_data.neg;
          ndig_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        stack_nxt[0] = digit;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
        mag_nxt  = mag_shift;
        ndig_nxt = ndig_r + 4'd1;
        if (conv_done) begin
          pfx_idx_nxt = 1'b0;
          state_nxt   = (pfx_len != 2'd0) ? ST_PFX : ST_DIG;
        end
      end
      ST_PFX: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pfx_char;
          out_last_nxt  = 1'b0;
          if ({1'b0, pfx_idx_r} == pfx_len - 2'd1) begin
            state_nxt = ST_DIG;
          end else begin
            pfx_idx_nxt = 1'b1;
          end
        end
      end
      ST_DIG: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(stack_r[0]);
          out_last_nxt  = (ndig_r == 4'd1);
          for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_nxt[i] = stack_r[i+1];
          end
          stack_nxt[STACK_DEPTH-1] = '0;
          ndig_nxt = ndig_r - 4'd1;
          if (ndig_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ndig_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ndig_r      <= ndig_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    mode_r     <= mode_nxt;
    neg_r      <= neg_nxt;
    pfx_idx_r  <= pfx_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_r[i] <= stack_nxt[i];
    end
  end

  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= 4'(STACK_DEPTH))
    else $error("digit count exceeds stack depth");

  a_dig_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG) |-> (ndig_r != 4'd0))
    else $error("emitting from an empty digit stack");

  a_bin_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && mode_r == MODE_BIN) |-> (ndig_r < BIN_DIGITS))
    else $error("binary conversion ran past eight digits");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG && can_emit && ndig_r == 4'd1)
      |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("final character not flagged");

endmodule
`default_nettype wire

/* rtl/radix_number_to_ascii.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// radix_number_to_ascii: integer to ASCII radix formatter
// Prints a signed 32-bit number in decimal, hex (0x), octal (0) or as eight
// binary digits of its low byte, one character per output transaction.
// ---------------------------------------------------------------------------
//  Channel | Direction | Payload          | Handshake
//  in_s    | in        | value[31:0] mode | valid/ready
//  out_m   | out       | char_code  last  | valid/ready
//
//  In the engine a number is loaded, its digits are extracted (a single
//  reciprocal multiply divides by ten), its prefix is emitted and then
//  its digits are output; octal with bit 31 set takes longest. A two-entry
//  queue takes new numbers while the engine works. Reset is synchronous and
//  empties the queue and the engine. When out_m.ready is low the current
//  character holds and the engine waits before emitting another.
// ---------------------------------------------------------------------------
module radix_number_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  rnta_in_if.sink     in_s,
  rnta_out_if.source  out_m
);
  import rnta_pkg::*;

  logic push_valid, push_ready;
  job_t push_data;
  logic job_valid, job_ready;
  job_t job_data;

  rnta_front u_front (
    .in_s       (in_s),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rnta_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job_data)
  );

  rnta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data),
    .out_m     (out_m)
  );

endmodule
`default_nettype wire
